// ===== hw/rtl/apis_pkg.sv =====
// Shared types and constants for the access point index search unit.
// No dependencies; imported by the search sequencer and the top level.
package apis_pkg;

   // Fixed field widths of the request and response items
   localparam int unsigned OFS_FIELD_W = 48;
   localparam int unsigned BITS_W      = 3;
   localparam int unsigned IDX_OUT_W   = 10;

   // Parameter defaults and register reset value
   localparam int unsigned MAX_POINTS_DEFAULT  = 1024;
   localparam int unsigned OFFSET_BITS_DEFAULT = 48;
   localparam logic [OFS_FIELD_W-1:0] SPAN_RESET = 48'd1048576;

   // Request kinds
   localparam logic REQ_EVENT  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic                   req_type;
      logic [OFS_FIELD_W-1:0] in_offset;
      logic [OFS_FIELD_W-1:0] out_offset;
      logic [BITS_W-1:0]      pending_bits;
      logic                   final_block;
      logic [OFS_FIELD_W-1:0] lookup_offset;
   } apis_req_type;

   typedef struct packed {
      logic                   point_added;
      logic                   table_full;
      logic                   found;
      logic [IDX_OUT_W-1:0]   point_index;
      logic [OFS_FIELD_W-1:0] point_out;
      logic [OFS_FIELD_W-1:0] point_in;
      logic [BITS_W-1:0]      point_bits;
   } apis_rsp_type;

   // Status from the search sequencer to the top level
   typedef struct packed {
      logic done;
      logic found;
   } apis_srch_stat_type;

endpackage

// ===== hw/rtl/apis_table_ram.sv =====
// Access point table storage: one write port, one registered read port.
// Depends on nothing; instantiated by the top level.
module apis_table_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 99
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/apis_search.sv =====
// Upper-bound binary search sequencer with one shared offset comparator.
// Depends on apis_pkg; drives the table read port and reports to the top level.
module apis_search #(
   parameter int unsigned MAX_POINTS = 1024,
   parameter int unsigned OFS_W      = 48
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [OFS_W-1:0]                       query,
   input  logic [$clog2(MAX_POINTS+1)-1:0]        count,
   output logic [$clog2(MAX_POINTS)-1:0]          rd_addr,
   input  logic [2*OFS_W+apis_pkg::BITS_W-1:0]    rd_data,
   output apis_pkg::apis_srch_stat_type           stat,
   output logic [$clog2(MAX_POINTS)-1:0]          hit_index,
   output logic [2*OFS_W+apis_pkg::BITS_W-1:0]    hit_entry
);
   import apis_pkg::*;

   localparam int unsigned CW = $clog2(MAX_POINTS + 1);
   localparam int unsigned IW = $clog2(MAX_POINTS);
   localparam int unsigned EW = 2 * OFS_W + BITS_W;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_PROBE = 2'b10
   } srch_state_type;

   srch_state_type state_ff, state_in;
   logic [CW-1:0]    first_ff, len_ff, first_in, len_in, half, mid_sum;
   logic [IW-1:0]    mid_ff;
   logic [OFS_W-1:0] query_ff;
   logic             done_ff, done_in, found_ff, found_in;
   logic [IW-1:0]    hit_index_ff;
   logic [EW-1:0]    hit_entry_ff;
   logic             less;

   // Shared comparator: query against the probed point's uncompressed offset
   always_comb begin
      half = len_ff >> 1;
      less = query_ff < rd_data[EW-1 -: OFS_W];
      if (less) begin
         first_in = first_ff;
         len_in   = half;
      end else begin
         first_in = CW'(mid_ff) + CW'(1);
         len_in   = len_ff - half - CW'(1);
      end
      mid_sum = first_in + (len_in >> 1);
   end

   // Next probe address: middle of the stored points on start, else of what remains
   always_comb begin
      if (state_ff == S_IDLE) begin
         rd_addr = IW'(count >> 1);
      end else begin
         rd_addr = mid_sum[IW-1:0];
      end
   end

   // Sequence the probes
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      found_in = found_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               found_in = 1'b0;
               if (count == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = S_PROBE;
               end
            end
         end
         S_PROBE: begin
            if (!less) begin
               found_in = 1'b1;
            end
            if (len_in == '0) begin
               done_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         found_ff <= found_in;
      end
   end

   // Hold search window, query and last hit
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         query_ff <= query;
         first_ff <= '0;
         len_ff   <= count;
         mid_ff   <= rd_addr;
      end else begin
         first_ff <= first_in;
         len_ff   <= len_in;
         mid_ff   <= rd_addr;
         if (!less) begin
            hit_index_ff <= mid_ff;
            hit_entry_ff <= rd_data;
         end
      end
   end

   assign stat.done  = done_ff;
   assign stat.found = found_ff;
   assign hit_index  = hit_index_ff;
   assign hit_entry  = hit_entry_ff;

`ifndef SYNTH
   // A probe never reaches past the stored points
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (CW'(mid_ff) < count))
      else $error("probe address beyond point count");

   // Done is a single-cycle pulse
   assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("search done held for more than one cycle");

   // The window shrinks on every probe
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) && (state_in == S_PROBE) |=> (len_ff < $past(len_ff)))
      else $error("search window did not shrink");
`endif

endmodule

// ===== hw/rtl/access_point_index_search_unit.sv =====
// Access point index search unit: top level with event handling, span register
// and result register. Depends on apis_pkg, apis_table_ram and apis_search.
// An event result passes through the pending result and the output register; a lookup
// first runs the binary search, then takes the same path. One item at a time: a new
// request is taken only after the last result has been loaded for output.
// Reset clears point count, last point and the state machines and loads span with
// 1048576; table contents stay undefined until written, with no clearing pass.
module access_point_index_search_unit #(
   parameter int unsigned MAX_POINTS  = apis_pkg::MAX_POINTS_DEFAULT,
   parameter int unsigned OFFSET_BITS = apis_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  apis_pkg::apis_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output apis_pkg::apis_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apis_pkg::OFS_FIELD_W-1:0]    csr_data
);
   import apis_pkg::*;

   localparam int unsigned OW = (OFFSET_BITS < OFS_FIELD_W) ? OFFSET_BITS : OFS_FIELD_W;
   localparam int unsigned CW = $clog2(MAX_POINTS + 1);
   localparam int unsigned IW = $clog2(MAX_POINTS);
   localparam int unsigned EW = 2 * OW + BITS_W;

   typedef enum logic [2:0] {
      T_IDLE   = 3'b001,
      T_SEARCH = 3'b010,
      T_RESULT = 3'b100
   } top_state_type;

   top_state_type          state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [OW-1:0]          last_ff, last_in;
   logic [OFS_FIELD_W-1:0] span_ff, span_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   apis_rsp_type           res_ff, res_in, rsp_data_ff;

   logic                   req_xfer, load_rsp;
   logic [OW-1:0]          cout, cin;
   logic                   grown, due, room;
   logic                   wr_en;
   logic [EW-1:0]          wr_data, rd_data, hit_entry;
   logic [IW-1:0]          rd_addr, hit_index;
   apis_srch_stat_type     stat;

   assign req_ready = (state_ff == T_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign load_rsp  = (state_ff == T_RESULT) && (!rsp_valid_ff || rsp_ready);

   // Decide whether a block-end event adds a point
   always_comb begin
      cout  = req_data.out_offset[OW-1:0];
      cin   = req_data.in_offset[OW-1:0];
      grown = (cout > last_ff) && (OFS_FIELD_W'(cout - last_ff) > span_ff);
      due   = !req_data.final_block && ((cout == '0) || grown);
      room  = count_ff < CW'(MAX_POINTS);
      wr_en = req_xfer && (req_data.req_type == REQ_EVENT) && due && room;
      wr_data = {cout, cin, req_data.pending_bits};
   end

   apis_table_ram #(
      .DEPTH (MAX_POINTS),
      .WIDTH (EW)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   apis_search #(
      .MAX_POINTS (MAX_POINTS),
      .OFS_W      (OW)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer && (req_data.req_type == REQ_LOOKUP)),
      .query     (req_data.lookup_offset[OW-1:0]),
      .count     (count_ff),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .stat      (stat),
      .hit_index (hit_index),
      .hit_entry (hit_entry)
   );

   // Advance control state, point count, last point and span
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      span_in      = span_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_valid && csr_ready) begin
         span_in = csr_data;
      end
      if (wr_en) begin
         count_in = count_ff + CW'(1);
         last_in  = cout;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         T_IDLE: begin
            if (req_xfer) begin
               state_in = (req_data.req_type == REQ_LOOKUP) ? T_SEARCH : T_RESULT;
            end
         end
         T_SEARCH: begin
            if (stat.done) begin
               state_in = T_RESULT;
            end
         end
         T_RESULT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         count_ff     <= '0;
         last_ff      <= '0;
         span_ff      <= SPAN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         span_ff      <= span_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Build the pending result from an event or a finished search
   always_comb begin
      res_in = res_ff;
      if (req_xfer && (req_data.req_type == REQ_EVENT)) begin
         res_in = '0;
         if (wr_en) begin
            res_in.point_added = 1'b1;
            res_in.point_index = IDX_OUT_W'(count_ff);
            res_in.point_out   = OFS_FIELD_W'(cout);
            res_in.point_in    = OFS_FIELD_W'(cin);
            res_in.point_bits  = req_data.pending_bits;
         end else if (due) begin
            res_in.table_full = 1'b1;
         end
      end else if ((state_ff == T_SEARCH) && stat.done) begin
         res_in = '0;
         if (stat.found) begin
            res_in.found       = 1'b1;
            res_in.point_index = IDX_OUT_W'(hit_index);
            res_in.point_out   = OFS_FIELD_W'(hit_entry[EW-1 -: OW]);
            res_in.point_in    = OFS_FIELD_W'(hit_entry[OW+BITS_W-1 -: OW]);
            res_in.point_bits  = hit_entry[BITS_W-1:0];
         end
      end
   end

   // Hold the pending result and the output register
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (load_rsp) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // Point count never passes the table depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond table depth");

   // Search completion is only seen while a lookup is in flight
   assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == T_SEARCH))
      else $error("search done outside a lookup");

   // A stored point bumps the count by exactly one
   assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("point count not advanced on store");

   // A lookup transfer starts the search
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_data.req_type == REQ_LOOKUP) |=> (state_ff == T_SEARCH))
      else $error("lookup did not enter search");
`endif

endmodule
